// ===== rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Opcodes, status codes, controller states, command/status bundles and the
// per-opcode pop/push counts shared by the stack machine ALU modules.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int NUM_REGS = 32;
  localparam int RIDX_W   = 5;
  localparam int OP_W     = 5;
  localparam int KMAX_W   = 2;   // index of a pushed word, up to four per op
  localparam int CNT3_W   = 3;   // width of a pop/push count

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 5'd0,
    OP_POP    = 5'd1,
    OP_ADD    = 5'd2,
    OP_SUB    = 5'd3,
    OP_MUL    = 5'd4,
    OP_DIV    = 5'd5,
    OP_MOD    = 5'd6,
    OP_AND    = 5'd7,
    OP_OR     = 5'd8,
    OP_XOR    = 5'd9,
    OP_NOT    = 5'd10,
    OP_SHL    = 5'd11,
    OP_SHR    = 5'd12,
    OP_CMPEQ  = 5'd13,
    OP_DUP    = 5'd14,
    OP_DUP2   = 5'd15,
    OP_SWAP   = 5'd16,
    OP_STORE  = 5'd17,
    OP_LOAD   = 5'd18,
    OP_MULFIX = 5'd19,
    OP_DIVFIX = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_COMMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              load_in;
    logic              rd;
    logic              alu;
    logic              div_start;
    logic              div_latch;
    logic              wr;
    logic [KMAX_W-1:0] wr_k;
    logic              commit;
    logic              emit;
    status_t           status;
  } cmd_t;

  typedef struct packed {
    op_t     op;
    status_t chk;
    logic    div_done;
    logic    out_free;
  } sts_t;

  function automatic logic is_legal(input op_t op);
    return op <= OP_DIVFIX;
  endfunction

  function automatic logic is_div(input op_t op);
    return (op == OP_DIV) || (op == OP_MOD) || (op == OP_DIVFIX);
  endfunction

  function automatic logic [CNT3_W-1:0] pops_of(input op_t op);
    unique case (op)
      OP_PUSH, OP_LOAD:                  return 3'd0;
      OP_POP, OP_NOT, OP_DUP, OP_STORE:  return 3'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
      OP_SHL, OP_SHR, OP_CMPEQ, OP_DUP2, OP_SWAP, OP_MULFIX,
      OP_DIVFIX:                         return 3'd2;
      default:                           return 3'd0;
    endcase
  endfunction

  function automatic logic [CNT3_W-1:0] puts_of(input op_t op);
    unique case (op)
      OP_POP, OP_STORE:  return 3'd0;
      OP_DUP, OP_SWAP:   return 3'd2;
      OP_DUP2:           return 3'd4;
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
      OP_XOR, OP_NOT, OP_SHL, OP_SHR, OP_CMPEQ, OP_LOAD, OP_MULFIX,
      OP_DIVFIX:         return 3'd1;
      default:           return 3'd0;
    endcase
  endfunction

endpackage

// ===== rtl/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// Signed restoring divider, 48-bit dividend by 32-bit divisor, one quotient
// bit per cycle. Returns low 32 bits of quotient and the remainder.
// ----------------------------------------------------------------------------
module sma_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  import sma_pkg::*;

  localparam int NUM_W = 48;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [WORD_W-1:0] rem_r, d_r;
  logic             nq_r, nr_r;
  logic [WORD_W:0]  sh, diff;

  assign sh   = {rem_r, q_r[NUM_W-1]};
  assign diff = sh - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num[NUM_W-1] ^ den[WORD_W-1];
      nr_r  <= num[NUM_W-1];
      q_r   <= num[NUM_W-1] ? -num : num;
      d_r   <= den[WORD_W-1] ? -den : den;
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      // keep the shifted partial remainder when the divisor does not fit
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[WORD_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = nq_r ? -q_r[WORD_W-1:0] : q_r[WORD_W-1:0];
  assign rem  = nr_r ? -rem_r : rem_r;

endmodule

// ===== rtl/sma_dp.sv =====
// ----------------------------------------------------------------------------
// sma_dp
// Datapath: operand stack memory, register file, ALU with multiplier,
// divider, error checks and the result word register.
// ----------------------------------------------------------------------------
module sma_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sma_pkg::cmd_t                        cmd,
  output sma_pkg::sts_t                        sts,
  input  logic [sma_pkg::OP_W-1:0]             in_op,
  input  logic signed [sma_pkg::WORD_W-1:0]    in_immediate,
  input  logic [sma_pkg::RIDX_W-1:0]           in_reg_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sma_pkg::WORD_W-1:0]    out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     out_depth,
  output logic [1:0]                           out_status
);
  import sma_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH+1);

  op_t               op_r;
  logic [WORD_W-1:0] imm_r;
  logic [RIDX_W-1:0] ri_r;
  logic [CW-1:0]     count_r;
  logic [WORD_W-1:0] top_r, b_r, rf_q, alu_r, alu_nxt, wdata;
  logic              rf_vq;
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rf_mem  [NUM_REGS];

  logic [CNT3_W-1:0] need, put;
  logic [CW-1:0]     base, new_cnt;
  logic [CW:0]       after;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic signed [2*WORD_W-1:0] prod;
  logic [47:0]       div_num;
  logic              div_done;
  logic [WORD_W-1:0] div_quo, div_rem;
  status_t           chk;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_top_r;
  logic [CW-1:0]     out_depth_r;
  status_t           out_status_r;

  assign need    = pops_of(op_r);
  assign put     = puts_of(op_r);
  assign base    = count_r - CW'(need);
  assign new_cnt = base + CW'(put);
  assign after   = {1'b0, count_r} - (CW+1)'(need) + (CW+1)'(put);
  assign rd_addr = AW'(count_r - CW'(2));
  assign wr_addr = AW'(base + CW'(cmd.wr_k));

  // underflow first, then overflow, then zero divisor
  always_comb begin
    chk = ST_OK;
    if (is_legal(op_r)) begin
      if (count_r < CW'(need))
        chk = ST_UNDER;
      else if (after > (CW+1)'(STACK_DEPTH))
        chk = ST_OVER;
      else if (is_div(op_r) && top_r == '0)
        chk = ST_DIVZ;
    end
  end

  assign prod = $signed(b_r) * $signed(top_r);

  always_comb begin
    case (op_r)
      OP_PUSH:   alu_nxt = imm_r;
      OP_ADD:    alu_nxt = b_r + top_r;
      OP_SUB:    alu_nxt = b_r - top_r;
      OP_MUL:    alu_nxt = prod[WORD_W-1:0];
      OP_AND:    alu_nxt = b_r & top_r;
      OP_OR:     alu_nxt = b_r | top_r;
      OP_XOR:    alu_nxt = b_r ^ top_r;
      OP_NOT:    alu_nxt = ~top_r;
      OP_SHL:    alu_nxt = b_r << top_r[4:0];
      OP_SHR:    alu_nxt = WORD_W'($signed(b_r) >>> top_r[4:0]);
      OP_CMPEQ:  alu_nxt = {{(WORD_W-1){1'b0}}, (b_r == top_r)};
      OP_DUP2:   alu_nxt = top_r;   // hold A, top_r moves during the writes
      OP_LOAD:   alu_nxt = rf_vq ? rf_q : '0;
      OP_MULFIX: alu_nxt = prod[FRAC_W+WORD_W-1:FRAC_W];
      default:   alu_nxt = alu_r;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_DUP:  wdata = top_r;
      OP_DUP2: wdata = cmd.wr_k[0] ? alu_r : b_r;
      OP_SWAP: wdata = (cmd.wr_k == '0) ? top_r : b_r;
      default: wdata = alu_r;
    endcase
  end

  assign div_num = (op_r == OP_DIVFIX) ? {b_r, {FRAC_W{1'b0}}}
                                       : {{FRAC_W{b_r[WORD_W-1]}}, b_r};

  sma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (top_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.wr)
      stk_mem[wr_addr] <= wdata;
    if (cmd.rd && count_r >= CW'(2))
      b_r <= stk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op_r == OP_STORE)
      rf_mem[ri_r] <= top_r;
    if (cmd.rd)
      rf_q <= rf_mem[ri_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rf_vq    <= 1'b0;
    end else begin
      if (cmd.commit && op_r == OP_STORE)
        rf_vld_r[ri_r] <= 1'b1;
      if (cmd.rd)
        rf_vq <= rf_vld_r[ri_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= op_t'(in_op);
      imm_r <= in_immediate;
      ri_r  <= in_reg_index;
    end
    if (cmd.alu)
      alu_r <= alu_nxt;
    else if (cmd.div_latch)
      alu_r <= (op_r == OP_MOD) ? div_rem : div_quo;
    if (cmd.wr)
      top_r <= wdata;
    else if (cmd.commit && put == '0)
      top_r <= (new_cnt == '0) ? '0 : b_r;
    if (cmd.emit) begin
      out_top_r    <= (count_r == '0) ? '0 : top_r;
      out_depth_r  <= count_r;
      out_status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit)
        count_r <= new_cnt;
      if (cmd.emit)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  assign sts.op       = op_r;
  assign sts.chk      = chk;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_top_r))
    else $error("stalled result word changed");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result word overwritten");

endmodule

// ===== rtl/sma_ctrl.sv =====
// ----------------------------------------------------------------------------
// sma_ctrl
// Sequencer: read operands, check, execute or divide, write pushed words,
// commit the stack count and hand the result word to the output register.
// ----------------------------------------------------------------------------
module sma_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sma_pkg::sts_t  sts,
  output sma_pkg::cmd_t  cmd
);
  import sma_pkg::*;

  state_t            state_r, state_nxt;
  logic [KMAX_W-1:0] k_r, k_nxt;
  status_t           st_r, st_nxt;
  logic [CNT3_W-1:0] put;

  assign put = puts_of(sts.op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.wr_k  = k_r;
    cmd.status = st_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        st_nxt = sts.chk;
        if (sts.chk != ST_OK || !is_legal(sts.op))
          state_nxt = S_FIN;
        else
          state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu = 1'b1;
        k_nxt   = '0;
        if (is_div(sts.op)) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (put == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        k_nxt  = k_r + 1'b1;
        if ({1'b0, k_r} == put - 3'd1)
          state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIV)
    else $error("divider started without wait");

  a_err_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> st_r == ST_OK)
    else $error("failed operation committed");

endmodule

// ===== rtl/stack_machine_alu.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu
// Stack machine data operations on a bounded word stack and 32 registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: in_op, in_immediate
//   and in_reg_index. Result channel (out_valid/out_ready) returns one word
//   per input: the new top of stack (zero if empty), the stack depth and a
//   status (ok, overflow, underflow, division by zero). A failing operation
//   leaves all state unchanged.
//   One operation at a time. After acceptance: operand read and check,
//   execute, for div, mod and divfix a wait on the bit-serial divider,
//   one write per pushed word, commit, hand-off. Failing and unknown
//   operations go from the check straight to the hand-off. in_ready is
//   high only while the sequencer is idle, so the next word is taken in
//   the cycle after the hand-off at the earliest.
//   Reset empties the stack and reads all registers as zero.
//   When the receiver stalls the result word holds in the output register;
//   the next operation runs and waits only at its own hand-off.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sma_pkg::OP_W-1:0]             in_op,
  input  logic signed [sma_pkg::WORD_W-1:0]    in_immediate,
  input  logic [sma_pkg::RIDX_W-1:0]           in_reg_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sma_pkg::WORD_W-1:0]    out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     out_depth,
  output logic [1:0]                           out_status
);
  import sma_pkg::*;

  // commands down, status up; nothing else crosses
  cmd_t cmd;
  sts_t sts;

  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sma_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_immediate  (in_immediate),
    .in_reg_index  (in_reg_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_status    (out_status)
  );

endmodule

// ===== tb/sv/stack_machine_alu_checker.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu_checker
// Watches both channels of the stack machine ALU, keeps its own copy of the
// operand stack and register file, predicts every result word and compares.
// ----------------------------------------------------------------------------
module stack_machine_alu_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [sma_pkg::OP_W-1:0]             in_op,
  input  logic signed [sma_pkg::WORD_W-1:0]    in_immediate,
  input  logic [sma_pkg::RIDX_W-1:0]           in_reg_index,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [sma_pkg::WORD_W-1:0]    out_top_value,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]     out_depth,
  input  logic [1:0]                           out_status,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sma_pkg::*;

  typedef struct packed {
    logic [31:0] top;
    logic [6:0]  depth;
    status_t     status;
  } result_t;

  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] regs [NUM_REGS];
  int          depth_now;
  result_t     expected_q [$];

  function automatic result_t snapshot(status_t st);
    result_t r;
    r.top    = (depth_now != 0) ? stk[depth_now-1] : 32'd0;
    r.depth  = 7'(depth_now);
    r.status = st;
    return r;
  endfunction

  function automatic result_t execute(logic [4:0] opc, logic [31:0] imm, logic [4:0] ri);
    op_t         op;
    int          need, put;
    logic [31:0] a, b;
    logic [31:0] res [4];
    longint      prod;
    op = op_t'(opc);
    if (opc > OP_DIVFIX) return snapshot(ST_OK);
    case (op)
      OP_PUSH, OP_LOAD: need = 0;
      OP_POP, OP_NOT, OP_DUP, OP_STORE: need = 1;
      default: need = 2;
    endcase
    case (op)
      OP_POP, OP_STORE: put = 0;
      OP_DUP, OP_SWAP: put = 2;
      OP_DUP2: put = 4;
      default: put = 1;
    endcase
    if (depth_now < need) return snapshot(ST_UNDER);
    if (depth_now - need + put > STACK_DEPTH) return snapshot(ST_OVER);
    a = (need >= 1) ? stk[depth_now-1] : 32'd0;
    b = (need >= 2) ? stk[depth_now-2] : 32'd0;
    if ((op == OP_DIV || op == OP_MOD || op == OP_DIVFIX) && a == 0)
      return snapshot(ST_DIVZ);
    for (int i = 0; i < 4; i++) res[i] = '0;
    case (op)
      OP_PUSH:  res[0] = imm;
      OP_ADD:   res[0] = b + a;
      OP_SUB:   res[0] = b - a;
      OP_MUL:   res[0] = b * a;
      OP_DIV:   res[0] = (b == 32'h8000_0000 && a == '1) ? b : 32'($signed(b) / $signed(a));
      OP_MOD:   res[0] = (a == '1) ? 32'd0 : 32'($signed(b) % $signed(a));
      OP_AND:   res[0] = b & a;
      OP_OR:    res[0] = b | a;
      OP_XOR:   res[0] = b ^ a;
      OP_NOT:   res[0] = ~a;
      OP_SHL:   res[0] = b << a[4:0];
      OP_SHR:   res[0] = $signed(b) >>> a[4:0];
      OP_CMPEQ: res[0] = (a == b) ? 32'd1 : 32'd0;
      OP_DUP:   begin res[0] = a; res[1] = a; end
      OP_DUP2:  begin res[0] = b; res[1] = a; res[2] = b; res[3] = a; end
      OP_SWAP:  begin res[0] = a; res[1] = b; end
      OP_STORE: regs[ri] = a;
      OP_LOAD:  res[0] = regs[ri];
      OP_MULFIX: begin
        prod = longint'($signed(b)) * longint'($signed(a));
        res[0] = prod[47:16];
      end
      OP_DIVFIX: begin
        prod = (longint'($signed(b)) * 65536) / longint'($signed(a));
        res[0] = prod[31:0];
      end
      default: ;
    endcase
    for (int i = 0; i < put; i++) stk[depth_now - need + i] = res[i];
    depth_now = depth_now - need + put;
    return snapshot(ST_OK);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      depth_now = 0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      expected_q.delete();
      fail_count <= 0;
      words_checked <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(execute(in_op, in_immediate, in_reg_index));
      if (out_valid && out_ready) begin
        words_checked <= words_checked + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word top=%h", out_top_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.top !== out_top_value || want.depth !== 7'(out_depth) ||
              want.status !== out_status) begin
            if (fail_count < 10)
              $display("mismatch: want top=%h depth=%0d st=%0d, got top=%h depth=%0d st=%0d",
                       want.top, want.depth, want.status, out_top_value, out_depth,
                       out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

// ===== tb/sv/stack_machine_alu_test.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu_test
// Drives operation words into the stack machine ALU with bursty gaps and a
// stalling receiver; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module stack_machine_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sma_pkg::*;

  localparam int DEPTH = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_op = '0;
  logic signed [31:0] in_immediate = '0;
  logic [4:0]  in_reg_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] out_top_value;
  logic [6:0]  out_depth;
  logic [1:0]  out_status;
  int          fail_count, pending, words_checked;
  int          sent = 0;
  int          shadow_depth = 0;
  bit          hold_off = 1'b0;

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stack_machine_alu #(.STACK_DEPTH(DEPTH)) uut (.*);

  stack_machine_alu_checker #(.STACK_DEPTH(DEPTH)) chk (.*);

  // Receiver: random stall pattern, plus a long hold-off window when asked.
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Pick an interesting operand: extremes, small values or raw noise.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return 32'($urandom_range(0, 40));
      5: return -32'($urandom_range(1, 40));
      default: return $urandom;
    endcase
  endfunction

  // Send one word and hold it until accepted.
  task automatic send_word(logic [4:0] op, logic [31:0] imm, logic [4:0] ri);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_immediate <= imm;
    in_reg_index <= ri;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Choose a random op, leaning on the stack level so most words do real work.
  task automatic random_word();
    logic [4:0] op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) op = 5'($urandom_range(21, 31));
    else if (shadow_depth < 3 && r < 60) op = OP_PUSH;
    else if (shadow_depth > DEPTH - 6 && r < 60) op = OP_POP;
    else if (r < 25) op = OP_PUSH;
    else op = 5'($urandom_range(OP_POP, OP_DIVFIX));
    case (op)
      OP_PUSH, OP_LOAD: if (shadow_depth < DEPTH) shadow_depth++;
      OP_POP, OP_STORE: if (shadow_depth > 0) shadow_depth--;
      OP_DUP: if (shadow_depth >= 1 && shadow_depth < DEPTH) shadow_depth++;
      OP_DUP2: if (shadow_depth >= 2 && shadow_depth <= DEPTH - 2) shadow_depth += 2;
      OP_NOT, OP_SWAP: ;
      default: if (op <= OP_DIVFIX && shadow_depth >= 2) shadow_depth--;
    endcase
    send_word(op, pick_value(), 5'($urandom));
  endtask

  initial begin
    int burst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: underflow on empty, a mix of ops, the divide corner cases.
    send_word(OP_POP, '0, '0);
    send_word(OP_ADD, '0, '0);
    send_word(OP_LOAD, '0, 5'd31);
    send_word(OP_PUSH, 32'h8000_0000, '0);
    send_word(OP_PUSH, 32'hFFFF_FFFF, '0);
    send_word(OP_DUP2, '0, '0);
    send_word(OP_DIV, '0, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_MOD, '0, '0);
    send_word(OP_PUSH, 32'd0, '0);
    send_word(OP_DIV, '0, '0);
    send_word(OP_MOD, '0, '0);
    send_word(OP_DIVFIX, '0, '0);
    send_word(OP_STORE, '0, 5'd31);
    send_word(OP_PUSH, 32'h7FFF_FFFF, 5'd0);
    send_word(OP_MULFIX, '0, '0);
    send_word(OP_PUSH, 32'd33, '0);
    send_word(OP_SHR, '0, '0);
    send_word(OP_DUP, '0, '0);
    send_word(OP_CMPEQ, '0, '0);
    send_word(OP_NOT, '0, '0);
    send_word(5'd31, '0, '0);
    // Fill to overflow.
    for (int i = 0; i < DEPTH + 1; i++) send_word(OP_PUSH, $urandom, '0);
    send_word(OP_DUP2, '0, '0);
    for (int i = 0; i < DEPTH; i++) send_word(OP_POP, '0, '0);
    shadow_depth = 0;

    // Random bursts; long receiver hold-offs while sent lies between 600 and 640.
    while (sent < 1150) begin
      burst = $urandom_range(1, 30);
      repeat (burst) random_word();
      idle_gap();
      if (sent > 600 && sent < 640 && !hold_off) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
    end
    in_valid <= 1'b0;

    // let the checker register the last accepted word before draining
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    $display("covered %0d words sent, %0d result words checked", sent, words_checked);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
